[hdl/sm4_pkg.sv]
// SM4 package: S-box, FK whitening words, round constants and round functions.
// Used by the sm4_block_cipher top level; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package sm4_pkg;

    typedef logic [31:0]  sm4_word_t;
    typedef logic [127:0] sm4_state_t;
    typedef logic [63:0]  sm4_half_t;

    localparam int ROUNDS = 32;

    // action codes
    localparam logic ACT_ENC = 1'b0;
    localparam logic ACT_DEC = 1'b1;

    // register select, taken from paddr[3]
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam sm4_word_t FK0 = 32'hA3B1BAC6;
    localparam sm4_word_t FK1 = 32'h56AA3350;
    localparam sm4_word_t FK2 = 32'h677D9197;
    localparam sm4_word_t FK3 = 32'hB27022DC;

    localparam logic [7:0] SBOX_TAB [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic sm4_word_t sbox_word(input sm4_word_t w);
        return {SBOX_TAB[w[31:24]], SBOX_TAB[w[23:16]], SBOX_TAB[w[15:8]], SBOX_TAB[w[7:0]]};
    endfunction

    function automatic sm4_word_t rotl(input sm4_word_t w, input int n);
        return (w << n) | (w >> (32 - n));
    endfunction

    // linear layer of the data rounds
    function automatic sm4_word_t lin_data(input sm4_word_t t);
        return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
    endfunction

    // linear layer of the key schedule
    function automatic sm4_word_t lin_key(input sm4_word_t t);
        return t ^ rotl(t, 13) ^ rotl(t, 23);
    endfunction

    // byte j of CK[i] is (4i+j)*7 mod 256
    function automatic sm4_word_t ck_word(input logic [4:0] i);
        sm4_word_t  w;
        logic [6:0] idx;
        logic [9:0] prod;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            idx  = {i, 2'(j)};
            prod = {3'b000, idx} * 10'd7;
            w    = {w[23:0], prod[7:0]};
        end
        return w;
    endfunction

    // one cipher round: state {x0,x1,x2,x3}, x0 in the top word
    function automatic sm4_state_t data_round(input sm4_state_t s, input sm4_word_t rk);
        sm4_word_t t;
        t = sbox_word(s[95:64] ^ s[63:32] ^ s[31:0] ^ rk);
        return {s[95:0], s[127:96] ^ lin_data(t)};
    endfunction

    // one key schedule round; the new round key lands in the low word
    function automatic sm4_state_t key_round(input sm4_state_t s, input sm4_word_t ck);
        sm4_word_t t;
        t = sbox_word(s[95:64] ^ s[63:32] ^ s[31:0] ^ ck);
        return {s[95:0], s[127:96] ^ lin_key(t)};
    endfunction

endpackage

`default_nettype wire

[hdl/sm4_in_if.sv]
// Input channel of the SM4 block: valid/ready plus action and 128-bit block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sm4_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] block_high;
    logic [63:0] block_low;

    modport source (output valid, output action, output block_high, output block_low,
                    input ready);
    modport sink   (input valid, input action, input block_high, input block_low,
                    output ready);
endinterface

`default_nettype wire

[hdl/sm4_out_if.sv]
// Output channel of the SM4 block: valid/ready plus the 128-bit result block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sm4_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_high;
    logic [63:0] out_low;

    modport source (output valid, output out_high, output out_low, input ready);
    modport sink   (input valid, input out_high, input out_low, output ready);
endinterface

`default_nettype wire

[hdl/sm4_block_cipher.sv]
// SM4 block cipher top level: APB key registers, key schedule unit, 32-stage round pipeline.
// Depends on sm4_pkg, sm4_in_if and sm4_out_if.
`timescale 1ns / 1ps
`default_nettype none

// SM4 encrypt/decrypt engine, 128-bit key and block. One round per pipeline stage:
// a new block may enter every cycle unless a stalled output or a round key rebuild
// holds the input off, so throughput is one block per clock. Each stage holds
// its own valid bit and loads whenever a bubble sits at or after it, so a stalled
// output only holds the full tail of the pipeline. The 32 round keys are kept in
// registers and rebuilt by a key schedule unit that does one round per cycle
// unless a key register write restarts it: after reset and after every key register
// write the input is held off through the write, the key load step and all key rounds.
// Keys sit at byte address 0 (key_high) and 8 (key_low); paddr[3] selects the register.
module sm4_block_cipher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output      logic [63:0] prdata,
    output      logic        pready,
    sm4_in_if.sink           blk_in,
    sm4_out_if.source        blk_out
);
    import sm4_pkg::*;

    localparam logic [4:0] KCNT_LAST = 5'(ROUNDS - 1);

    sm4_half_t  key_high_reg;
    sm4_half_t  key_low_reg;
    logic       kload_reg;
    logic       kbusy_reg;
    logic [4:0] kcnt_reg;
    sm4_state_t kst_reg;
    sm4_state_t kst_next;
    sm4_word_t  rk_reg [ROUNDS];

    logic [ROUNDS-1:0] vld_reg;
    logic [ROUNDS-1:0] dec_reg;
    sm4_state_t        st_reg [ROUNDS];
    logic [ROUNDS-1:0] stg_rdy;

    logic cfg_wr;
    logic in_open;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[3] == REG_KEY_LOW) ? key_low_reg : key_high_reg;

    // ---------------- key registers and key schedule ----------------
    assign kst_next = key_round(kst_reg, ck_word(kcnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            kload_reg    <= 1'b1;
            kbusy_reg    <= 1'b0;
            kcnt_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == REG_KEY_LOW)
                key_low_reg <= pwdata;
            else
                key_high_reg <= pwdata;
            kload_reg <= 1'b1;
            kbusy_reg <= 1'b0;
        end
        else if (kload_reg)
        begin
            kload_reg <= 1'b0;
            kbusy_reg <= 1'b1;
            kcnt_reg  <= '0;
        end
        else if (kbusy_reg)
        begin
            kcnt_reg <= kcnt_reg + 5'd1;
            if (kcnt_reg == KCNT_LAST)
                kbusy_reg <= 1'b0;
        end
    end

    // round keys shift in from the top: after the last key round rk_reg[i] holds rk[i]
    always_ff @(posedge clk)
    begin
        if (!cfg_wr && kload_reg)
        begin
            kst_reg <= {key_high_reg[63:32] ^ FK0, key_high_reg[31:0] ^ FK1,
                        key_low_reg[63:32] ^ FK2, key_low_reg[31:0] ^ FK3};
        end
        else if (!cfg_wr && kbusy_reg)
        begin
            kst_reg <= kst_next;
            for (int i = 0; i < ROUNDS - 1; i++)
                rk_reg[i] <= rk_reg[i + 1];
            rk_reg[ROUNDS - 1] <= kst_next[31:0];
        end
    end

    // ---------------- round pipeline ----------------
    // hold input off while round keys are rebuilt or a key write is in flight
    assign in_open      = ~kload_reg & ~kbusy_reg & ~cfg_wr;
    assign blk_in.ready = stg_rdy[0] & in_open;

    genvar g;
    generate
        for (g = 0; g < ROUNDS; g++)
        begin : g_stage
            logic       prv_vld;
            logic       prv_dec;
            sm4_state_t prv_st;
            sm4_word_t  rkey;

            // a stage may load when it or any later stage is empty or the output drains
            assign stg_rdy[g] = blk_out.ready | ~(&vld_reg[ROUNDS-1:g]);

            if (g == 0)
            begin : g_head
                assign prv_vld = blk_in.valid & in_open;
                assign prv_dec = blk_in.action;
                assign prv_st  = {blk_in.block_high, blk_in.block_low};
            end
            else
            begin : g_body
                assign prv_vld = vld_reg[g - 1];
                assign prv_dec = dec_reg[g - 1];
                assign prv_st  = st_reg[g - 1];
            end

            assign rkey = (prv_dec == ACT_DEC) ? rk_reg[ROUNDS - 1 - g] : rk_reg[g];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else if (stg_rdy[g])
                    vld_reg[g] <= prv_vld;
            end

            always_ff @(posedge clk)
            begin
                if (stg_rdy[g] && prv_vld)
                begin
                    dec_reg[g] <= prv_dec;
                    st_reg[g]  <= data_round(prv_st, rkey);
                end
            end
        end
    endgenerate

    // result is the final state with its words reversed
    assign blk_out.valid    = vld_reg[ROUNDS - 1];
    assign blk_out.out_high = {st_reg[ROUNDS - 1][31:0],  st_reg[ROUNDS - 1][63:32]};
    assign blk_out.out_low  = {st_reg[ROUNDS - 1][95:64], st_reg[ROUNDS - 1][127:96]};

endmodule

`default_nettype wire
